// ===== hw/rtl/mcs_pkg.sv =====
// Package with shared types, character codes and pattern tables of the charset sniffer.
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

	localparam int POSITION_BITS = 16;
	localparam int LIMIT_BITS = 16;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1024;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_CNT_BITS = 3;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LOW_C  = 8'h63;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;

	localparam logic [2:0] META_LEN_M1 = 3'd4;
	localparam logic [2:0] CHARSET_LEN_M1 = 3'd6;

	typedef enum logic [6:0] {
		MODE_META    = 7'b0000001,
		MODE_CHARSET = 7'b0000010,
		MODE_EQ      = 7'b0000100,
		MODE_SKIP    = 7'b0001000,
		MODE_WAIT    = 7'b0010000,
		MODE_VALUE   = 7'b0100000,
		MODE_DONE    = 7'b1000000
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] label_byte;
		logic       found;
		logic       label_last;
	} result_t;

	// Results of one byte, compacted so that first is always used before second.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} result_pair_t;

	// Characters of "<meta".
	function automatic logic [7:0] meta_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h3C;
			3'd1: ch = 8'h6D;
			3'd2: ch = 8'h65;
			3'd3: ch = 8'h74;
			3'd4: ch = 8'h61;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Characters of "charset".
	function automatic logic [7:0] charset_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h63;
			3'd1: ch = 8'h68;
			3'd2: ch = 8'h61;
			3'd3: ch = 8'h72;
			3'd4: ch = 8'h73;
			3'd5: ch = 8'h65;
			3'd6: ch = 8'h74;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcs_scanner.sv =====
// Scan state machine: matches the meta tag and charset attribute and produces label results.
`timescale 1ns / 1ps
`default_nettype none

module mcs_scanner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic [7:0]                          doc_byte,
	input  wire logic                                doc_end,
	input  wire logic [mcs_pkg::LIMIT_BITS-1:0]      window_len,
	output mcs_pkg::result_pair_t                    results
);

	localparam logic [mcs_pkg::POSITION_BITS-1:0] POS_MAX = '1;

	mcs_pkg::scan_mode_t mode_q, mode_n;
	logic [2:0] match_q, match_n;
	logic [mcs_pkg::POSITION_BITS-1:0] pos_q, pos_n;
	logic [7:0] held_q, held_n;
	logic held_valid_q, held_valid_n;
	logic fin_q, fin_n;

	logic [7:0] ch;
	logic examined;
	logic value_end;
	logic emit_a, emit_b, emit_c;
	mcs_pkg::result_t res_a, res_b, res_c;

	assign ch = (doc_byte >= mcs_pkg::CH_UP_A && doc_byte <= mcs_pkg::CH_UP_Z) ?
		doc_byte + 8'd32 : doc_byte;
	assign examined = !fin_q && (32'(pos_q) < 32'(window_len));
	assign value_end = (ch == mcs_pkg::CH_DQUOTE) || (ch == mcs_pkg::CH_SQUOTE) ||
		(ch == mcs_pkg::CH_SPACE) || (ch == mcs_pkg::CH_SEMI) || (ch == mcs_pkg::CH_GT);

	always_comb begin
		mode_n = mode_q;
		match_n = match_q;
		held_n = held_q;
		held_valid_n = held_valid_q;
		fin_n = fin_q;
		emit_a = 1'b0;
		emit_b = 1'b0;
		emit_c = 1'b0;
		res_a = '{label_byte: held_q, found: 1'b1, label_last: 1'b0};

		if (examined) begin
			unique case (mode_q)
				mcs_pkg::MODE_META: begin
					if (ch == mcs_pkg::meta_char(match_q)) begin
						if (match_q == mcs_pkg::META_LEN_M1) begin
							mode_n = mcs_pkg::MODE_CHARSET;
							match_n = 3'd0;
						end else begin
							match_n = match_q + 3'd1;
						end
					end else begin
						match_n = (ch == mcs_pkg::CH_LT) ? 3'd1 : 3'd0;
					end
				end
				mcs_pkg::MODE_CHARSET: begin
					if (ch == mcs_pkg::CH_GT) begin
						mode_n = mcs_pkg::MODE_META;
						match_n = 3'd0;
					end else if (ch == mcs_pkg::charset_char(match_q)) begin
						if (match_q == mcs_pkg::CHARSET_LEN_M1) begin
							mode_n = mcs_pkg::MODE_EQ;
							match_n = 3'd0;
						end else begin
							match_n = match_q + 3'd1;
						end
					end else begin
						match_n = (ch == mcs_pkg::CH_LOW_C) ? 3'd1 : 3'd0;
					end
				end
				mcs_pkg::MODE_EQ: begin
					if (ch == mcs_pkg::CH_GT) begin
						mode_n = mcs_pkg::MODE_META;
					end else if (ch == mcs_pkg::CH_EQ) begin
						mode_n = mcs_pkg::MODE_SKIP;
					end
				end
				mcs_pkg::MODE_SKIP: begin
					if (ch == mcs_pkg::CH_GT) begin
						mode_n = mcs_pkg::MODE_META;
					end else if (ch == mcs_pkg::CH_SEMI) begin
						mode_n = mcs_pkg::MODE_WAIT;
					end else if (ch != mcs_pkg::CH_SPACE && ch != mcs_pkg::CH_DQUOTE &&
							ch != mcs_pkg::CH_SQUOTE) begin
						held_n = ch;
						held_valid_n = 1'b1;
						mode_n = mcs_pkg::MODE_VALUE;
					end
				end
				mcs_pkg::MODE_WAIT: begin
					if (ch == mcs_pkg::CH_GT) begin
						mode_n = mcs_pkg::MODE_META;
					end
				end
				mcs_pkg::MODE_VALUE: begin
					if (value_end) begin
						emit_a = 1'b1;
						res_a.label_last = 1'b1;
						held_valid_n = 1'b0;
						fin_n = 1'b1;
						mode_n = mcs_pkg::MODE_DONE;
					end else begin
						emit_a = held_valid_q;
						held_n = ch;
						held_valid_n = 1'b1;
					end
				end
				mcs_pkg::MODE_DONE: begin
					mode_n = mcs_pkg::MODE_DONE;
				end
				default: begin
					mode_n = mcs_pkg::MODE_DONE;
				end
			endcase
		end

		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

		// The window closes while a value is open: the held byte ends the label.
		res_b = '{label_byte: held_n, found: 1'b1, label_last: 1'b1};
		if (examined && !fin_n && !(32'(pos_n) < 32'(window_len)) &&
				mode_n == mcs_pkg::MODE_VALUE && held_valid_n) begin
			emit_b = 1'b1;
			held_valid_n = 1'b0;
			fin_n = 1'b1;
			mode_n = mcs_pkg::MODE_DONE;
		end

		res_c = held_valid_n ?
			'{label_byte: held_n, found: 1'b1, label_last: 1'b1} :
			'{label_byte: 8'd0, found: 1'b0, label_last: 1'b1};
		if (doc_end) begin
			emit_c = !fin_n;
			mode_n = mcs_pkg::MODE_META;
			match_n = 3'd0;
			pos_n = '0;
			held_n = 8'd0;
			held_valid_n = 1'b0;
			fin_n = 1'b0;
		end
	end

	// Window end and document end never both emit, so at most two results occur.
	always_comb begin
		results.count = step ? (2'(emit_a) + 2'(emit_b) + 2'(emit_c)) : 2'd0;
		results.first = emit_a ? res_a : (emit_b ? res_b : res_c);
		results.second = emit_b ? res_b : res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mcs_pkg::MODE_META;
			match_q <= 3'd0;
			pos_q <= '0;
			held_q <= 8'd0;
			held_valid_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			match_q <= match_n;
			pos_q <= pos_n;
			held_q <= held_n;
			held_valid_q <= held_valid_n;
			fin_q <= fin_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mcs_out_queue.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module mcs_out_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mcs_pkg::result_pair_t wr,
	input  wire logic                  pop_ready,
	output mcs_pkg::result_t           head,
	output logic                       not_empty,
	output logic                       has_room
);

	mcs_pkg::result_t entries_q [mcs_pkg::QUEUE_DEPTH];
	logic [mcs_pkg::QUEUE_PTR_BITS-1:0] wp_q, rp_q;
	logic [mcs_pkg::QUEUE_CNT_BITS-1:0] cnt_q;
	logic pop;

	assign not_empty = (cnt_q != '0);
	// Room for the worst case of two results from one byte.
	assign has_room = (cnt_q <= mcs_pkg::QUEUE_CNT_BITS'(mcs_pkg::QUEUE_DEPTH - 2));
	assign head = entries_q[rp_q];
	assign pop = not_empty && pop_ready;

	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			entries_q[wp_q] <= wr.first;
		end
		if (wr.count == 2'd2) begin
			entries_q[wp_q + 1'b1] <= wr.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + mcs_pkg::QUEUE_PTR_BITS'(wr.count);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + mcs_pkg::QUEUE_CNT_BITS'(wr.count) -
				mcs_pkg::QUEUE_CNT_BITS'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/meta_charset_sniffer_top.sv =====
// Top level of the HTML meta charset sniffer: input stage, scanner and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------------
// s_*       | in        | s_tdata = doc_byte[7:0], s_tlast = doc_end
// m_*       | out       | m_tdata = label_byte[7:0], m_tuser = found, m_tlast = label_last
// cfg_*     | in        | cfg_wdata = scan window length [15:0], written when cfg_we is high
//
// The block takes one byte request per cycle, sustained while the result queue has room. Each
// accepted byte waits in the input register for the scan step; when the step fires, its results
// are written into the queue and then show on m_tvalid. A byte can yield two results (a label byte
// plus the final one at window or document end); these sit in a four-entry queue that drains
// one result per cycle while m_tready is high. The scan step waits while the queue holds three or
// more results, the input register then keeps its byte and s_tready falls in that same cycle;
// there is no combinational path from m_tready to s_tready. Reset clears the scan state and sets
// the window length to 1024; no clearing pass is needed.
module meta_charset_sniffer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] doc_byte
	input  wire logic        s_tlast,   // doc_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] label_byte
	output logic             m_tuser,   // [0] found
	output logic             m_tlast,   // label_last
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata  // [15:0] scan window length
);

	logic [mcs_pkg::LIMIT_BITS-1:0] window_len_q;

	// Input register: one accepted byte waiting for the scan step.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic accept;
	logic step;
	logic room;
	mcs_pkg::result_pair_t results;
	mcs_pkg::result_t head;

	// The scan step fires when a byte is held and the queue can absorb its results.
	assign step = valid_s1 && room;
	assign s_tready = !valid_s1 || step;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= mcs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			window_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// The byte payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	mcs_scanner u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.doc_byte    (byte_s1),
		.doc_end     (end_s1),
		.window_len  (window_len_q),
		.results     (results)
	);

	mcs_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (results),
		.pop_ready (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.has_room  (room)
	);

	assign m_tdata = head.label_byte;
	assign m_tuser = head.found;
	assign m_tlast = head.label_last;

endmodule

`default_nettype wire
